// ===== rtl/glb_pkg.sv =====
// shared types and constants for the glb json chunk locator
// no dependencies; used by glb_core, glb_out_skid and the top level
`default_nettype none

package glb_pkg;

    // container constants
    localparam logic [31:0] GLB_MAGIC      = 32'h4654_6C67;
    localparam logic [31:0] GLB_VERSION    = 32'd2;
    localparam logic [31:0] GLB_JSON_TYPE  = 32'h4E4F_534A;
    localparam logic [31:0] GLB_HDR_BYTES  = 32'd12;
    localparam logic [32:0] GLB_CHDR_BYTES = 33'd8;
    localparam logic [31:0] FILE_SIZE_RST  = 32'd12;

    // field byte counts at which a word is complete
    localparam logic [3:0] FBC_WORD0 = 4'd4;
    localparam logic [3:0] FBC_WORD1 = 4'd8;
    localparam logic [3:0] FBC_WORD2 = 4'd12;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHDR   = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_JSON   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_MAGIC      = 3'd2;
    localparam logic [2:0] ST_VERSION    = 3'd3;
    localparam logic [2:0] ST_LEN_SIZE   = 3'd4;
    localparam logic [2:0] ST_MISALIGNED = 3'd5;
    localparam logic [2:0] ST_OVERRUN    = 3'd6;
    localparam logic [2:0] ST_NO_JSON    = 3'd7;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic       is_end;
        logic [2:0] status;
    } res_t;

    // push strobe from the core to the output buffer
    typedef struct packed {
        logic push;
    } push_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/glb_core.sv =====
// input register, parser state and the per-byte parse step
// depends on glb_pkg
`default_nettype none

module glb_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // byte input
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_eof,
    // result toward the output buffer
    output glb_pkg::push_ctl_t push_ctl,
    input  wire logic        out_space,
    output glb_pkg::res_t    res
);

    // file size register
    logic [31:0] file_size_reg;

    // input stage
    logic        stg_valid_reg;
    logic [7:0]  stg_byte_reg;
    logic        stg_eof_reg;

    // parser state
    logic [2:0]  phase_reg,  phase_next;
    logic [3:0]  fbc_reg,    fbc_next;
    logic [31:0] word_reg,   word_next;
    logic [31:0] dlen_reg,   dlen_next;
    logic [31:0] off_reg,    off_next;
    logic [31:0] cbl_reg,    cbl_next;

    // step outputs
    logic        st_hit;
    logic [2:0]  st_code;
    logic        payload;
    logic        has_res;
    logic        advance;

    // boundary check result: bit 3 ends the file, low bits give the code
    logic [3:0]  bnd;
    logic [31:0] bnd_off;
    logic [31:0] bnd_dlen;
    logic        bnd_use;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= glb_pkg::FILE_SIZE_RST;
        end else if (cfg_valid) begin
            file_size_reg <= cfg_data;
        end
    end

    // chunk boundary decision
    always_comb begin
        logic [32:0] nxt;
        nxt = {1'b0, bnd_off} + glb_pkg::GLB_CHDR_BYTES;
        if (nxt > {1'b0, bnd_dlen} || nxt > {1'b0, file_size_reg}) begin
            bnd = {1'b1, glb_pkg::ST_NO_JSON};
        end else if (bnd_off[1:0] != 2'b00) begin
            bnd = {1'b1, glb_pkg::ST_MISALIGNED};
        end else begin
            bnd = {1'b0, glb_pkg::ST_OK};
        end
    end

    // parse step for the byte held in the input stage
    always_comb begin
        logic [31:0] wa_n;
        logic [3:0]  fbc_n;
        logic [31:0] off_n;
        logic [31:0] cbl_n;
        wa_n  = {stg_byte_reg, word_reg[31:8]};
        fbc_n = fbc_reg + 4'd1;
        off_n = off_reg + 32'd1;
        cbl_n = cbl_reg - 32'd1;

        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        word_next  = word_reg;
        dlen_next  = dlen_reg;
        off_next   = off_reg;
        cbl_next   = cbl_reg;
        st_hit     = 1'b0;
        st_code    = glb_pkg::ST_OK;
        payload    = 1'b0;
        bnd_off    = off_n;
        bnd_dlen   = dlen_reg;
        bnd_use    = 1'b0;

        case (phase_reg)
            glb_pkg::PH_HEADER: begin
                if (fbc_reg == 4'd0 && file_size_reg < glb_pkg::GLB_HDR_BYTES) begin
                    st_hit  = 1'b1;
                    st_code = glb_pkg::ST_SHORT;
                end else begin
                    word_next = wa_n;
                    fbc_next  = fbc_n;
                    off_next  = off_n;
                    if (fbc_n == glb_pkg::FBC_WORD0) begin
                        if (wa_n != glb_pkg::GLB_MAGIC) begin
                            st_hit  = 1'b1;
                            st_code = glb_pkg::ST_MAGIC;
                        end
                    end else if (fbc_n == glb_pkg::FBC_WORD1) begin
                        if (wa_n != glb_pkg::GLB_VERSION) begin
                            st_hit  = 1'b1;
                            st_code = glb_pkg::ST_VERSION;
                        end
                    end else if (fbc_n == glb_pkg::FBC_WORD2) begin
                        dlen_next = wa_n;
                        if (wa_n > file_size_reg) begin
                            st_hit  = 1'b1;
                            st_code = glb_pkg::ST_LEN_SIZE;
                        end else begin
                            bnd_dlen = wa_n;
                            bnd_use  = 1'b1;
                        end
                    end
                end
            end
            glb_pkg::PH_CHDR: begin
                word_next = wa_n;
                fbc_next  = fbc_n;
                off_next  = off_n;
                if (fbc_n == glb_pkg::FBC_WORD0) begin
                    cbl_next = wa_n;
                end else if (fbc_n == glb_pkg::FBC_WORD1) begin
                    if (off_n > file_size_reg || off_n > dlen_reg ||
                        cbl_reg > (dlen_reg - off_n)) begin
                        st_hit  = 1'b1;
                        st_code = glb_pkg::ST_OVERRUN;
                    end else if (wa_n == glb_pkg::GLB_JSON_TYPE) begin
                        if (cbl_reg == 32'd0) begin
                            st_hit  = 1'b1;
                            st_code = glb_pkg::ST_OK;
                        end else begin
                            phase_next = glb_pkg::PH_JSON;
                        end
                    end else if (cbl_reg == 32'd0) begin
                        bnd_use = 1'b1;
                    end else begin
                        phase_next = glb_pkg::PH_SKIP;
                    end
                end
            end
            glb_pkg::PH_SKIP: begin
                off_next = off_n;
                cbl_next = cbl_n;
                if (cbl_n == 32'd0) begin
                    bnd_use = 1'b1;
                end
            end
            glb_pkg::PH_JSON: begin
                payload  = 1'b1;
                off_next = off_n;
                cbl_next = cbl_n;
                if (cbl_n == 32'd0) begin
                    st_hit  = 1'b1;
                    st_code = glb_pkg::ST_OK;
                end
            end
            default: begin
            end
        endcase

        // boundary reached: either end the file or start a chunk header
        if (bnd_use) begin
            if (bnd[3]) begin
                st_hit  = 1'b1;
                st_code = bnd[2:0];
            end else begin
                phase_next = glb_pkg::PH_CHDR;
                fbc_next   = 4'd0;
            end
        end

        if (st_hit) begin
            phase_next = glb_pkg::PH_DONE;
        end

        // end of file: early end reports short, then the parser starts over
        if (stg_eof_reg) begin
            if (phase_reg != glb_pkg::PH_DONE && !st_hit) begin
                st_hit  = 1'b1;
                st_code = glb_pkg::ST_SHORT;
            end
            phase_next = glb_pkg::PH_HEADER;
            fbc_next   = 4'd0;
            word_next  = 32'd0;
            dlen_next  = 32'd0;
            off_next   = 32'd0;
            cbl_next   = 32'd0;
        end
    end

    assign has_res  = st_hit || payload;
    assign advance  = stg_valid_reg && (!has_res || out_space);
    assign in_ready = !stg_valid_reg || advance;

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (in_ready) begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            stg_byte_reg <= in_byte;
            stg_eof_reg  <= in_eof;
        end
    end

    // parser state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= glb_pkg::PH_HEADER;
            fbc_reg   <= 4'd0;
            word_reg  <= 32'd0;
            dlen_reg  <= 32'd0;
            off_reg   <= 32'd0;
            cbl_reg   <= 32'd0;
        end else if (advance) begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            word_reg  <= word_next;
            dlen_reg  <= dlen_next;
            off_reg   <= off_next;
            cbl_reg   <= cbl_next;
        end
    end

    // result toward the buffer
    assign push_ctl.push  = advance && has_res;
    assign res.out_byte   = payload ? stg_byte_reg : 8'd0;
    assign res.is_payload = payload;
    assign res.is_end     = st_hit;
    assign res.status     = st_hit ? st_code : glb_pkg::ST_OK;

`ifndef ASSERT_OFF
    // a pushed result without payload always closes the file
    a_nopay_end: assert property (@(posedge aclk) disable iff (!aresetn)
        push_ctl.push && !res.is_payload |-> res.is_end)
        else $error("result without payload that does not end the file");

    // a result is never pushed into a full buffer
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_ctl.push |-> out_space)
        else $error("result pushed while buffer full");

    // after an end-of-file byte is taken the parser is back in the header phase
    a_eof_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && stg_eof_reg |=> phase_reg == glb_pkg::PH_HEADER && fbc_reg == 4'd0)
        else $error("parser did not restart after end of file");

    // once done, no result until end of file
    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == glb_pkg::PH_DONE && !stg_eof_reg |-> !has_res)
        else $error("result produced after the file ended");
`endif

endmodule

`default_nettype wire

// ===== rtl/glb_out_skid.sv =====
// two-entry result buffer between the parse step and the output channel
// depends on glb_pkg
`default_nettype none

module glb_out_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  glb_pkg::push_ctl_t push_ctl,
    input  glb_pkg::res_t      push_res,
    output logic               space,
    output logic               out_valid,
    input  wire logic          out_ready,
    output glb_pkg::res_t      out_res
);

    glb_pkg::res_t ent_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_res   = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_ctl.push) begin
            ent_reg[wr_ptr_reg] <= push_res;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push_ctl.push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push_ctl.push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // fill count never exceeds the two entries
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    // pointers differ exactly when one entry is held
    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_ptr_reg != rd_ptr_reg) == (count_reg == 2'd1))
        else $error("result buffer pointers disagree with count");

    // a push with no pop raises the count by one
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push_ctl.push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("result buffer count not updated on push");
`endif

endmodule

`default_nettype wire

// ===== rtl/glb_json_chunk_locator.sv =====
// top level of the glb json chunk locator: stream ports and config register port
// depends on glb_pkg, glb_core and glb_out_skid
`default_nettype none

// Streams a GLB file in one byte per request and returns the bytes of its
// first JSON chunk; the last result carries the end flag and a status code
// (0 ok, 1 short or early end of file, 2 magic, 3 version, 4 length above
// size, 5 misaligned chunk, 6 chunk overrun, 7 no JSON chunk). Write the file
// size on the cfg port before the file starts. One byte is taken every clock
// while the result buffer has space, a rate set by the single-pass parse step
// that runs on the byte held in the input register; its result is registered
// into a two-entry result buffer that drives the output. Bytes that follow
// the end of the file give no result until the byte marked with s_tlast,
// which restarts the parser.
module glb_json_chunk_locator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // file size register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_file
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
    output logic             m_tuser,   // is_payload
    output logic             m_tlast    // is_end
);

    glb_pkg::push_ctl_t push_ctl;
    glb_pkg::res_t      core_res;
    glb_pkg::res_t      out_res;
    logic               out_space;

    // parse step
    glb_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_eof    (s_tlast),
        .push_ctl  (push_ctl),
        .out_space (out_space),
        .res       (core_res)
    );

    // result buffer
    glb_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_ctl  (push_ctl),
        .push_res  (core_res),
        .space     (out_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // output packing
    assign m_tdata = {5'd0, out_res.status, out_res.out_byte};
    assign m_tuser = out_res.is_payload;
    assign m_tlast = out_res.is_end;

endmodule

`default_nettype wire

// ===== test/glb_json_chunk_locator_checker.sv =====
// result checker for the glb json chunk locator: follows the file size writes
// and the byte requests, predicts each result and compares them in order
// depends on glb_pkg for the result type, phases, status codes and constants
module glb_json_chunk_locator_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_file
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
    input  wire logic        m_tuser,   // is_payload
    input  wire logic        m_tlast,   // is_end
    output int               fail_count,
    output int               pending
);

    // parser copy kept alongside the block
    logic [31:0] size_reg;
    logic [2:0]  parse_phase;
    logic [3:0]  word_bytes;
    logic [31:0] word_acc;
    logic [31:0] glb_length;
    logic [31:0] file_pos;
    logic [31:0] chunk_left;

    glb_pkg::res_t json_out_q[$];
    glb_pkg::res_t oldest;

    task automatic clear_parse();
        parse_phase = glb_pkg::PH_HEADER;
        word_bytes  = 4'd0;
        word_acc    = 32'd0;
        glb_length  = 32'd0;
        file_pos    = 32'd0;
        chunk_left  = 32'd0;
    endtask

    // little-endian word assembly, one byte at a time
    task automatic shift_in(input logic [7:0] b);
        word_acc   = {b, word_acc[31:8]};
        word_bytes = word_bytes + 4'd1;
        file_pos   = file_pos + 32'd1;
    endtask

    // chunk boundary: either start a chunk header or end the file
    task automatic chunk_boundary(output logic ends, output logic [2:0] code);
        logic [32:0] next_pos;
        next_pos = {1'b0, file_pos} + glb_pkg::GLB_CHDR_BYTES;
        ends = 1'b1;
        code = glb_pkg::ST_NO_JSON;
        if (next_pos > {1'b0, glb_length} || next_pos > {1'b0, size_reg}) begin
            code = glb_pkg::ST_NO_JSON;
        end else if (file_pos[1:0] != 2'b00) begin
            code = glb_pkg::ST_MISALIGNED;
        end else begin
            ends        = 1'b0;
            code        = glb_pkg::ST_OK;
            parse_phase = glb_pkg::PH_CHDR;
            word_bytes  = 4'd0;
        end
    endtask

    // one accepted byte: advance the parser and queue the result it causes
    task automatic locate_step(input logic [7:0] b, input logic eof);
        logic          was_done;
        logic          payload;
        logic          ends;
        logic [2:0]    code;
        glb_pkg::res_t r;
        was_done = (parse_phase == glb_pkg::PH_DONE);
        payload  = 1'b0;
        ends     = 1'b0;
        code     = glb_pkg::ST_OK;
        case (parse_phase)
            glb_pkg::PH_HEADER: begin
                if (word_bytes == 4'd0 && size_reg < glb_pkg::GLB_HDR_BYTES) begin
                    ends = 1'b1;
                    code = glb_pkg::ST_SHORT;
                end else begin
                    shift_in(b);
                    if (word_bytes == glb_pkg::FBC_WORD0) begin
                        if (word_acc != glb_pkg::GLB_MAGIC) begin
                            ends = 1'b1;
                            code = glb_pkg::ST_MAGIC;
                        end
                    end else if (word_bytes == glb_pkg::FBC_WORD1) begin
                        if (word_acc != glb_pkg::GLB_VERSION) begin
                            ends = 1'b1;
                            code = glb_pkg::ST_VERSION;
                        end
                    end else if (word_bytes == glb_pkg::FBC_WORD2) begin
                        glb_length = word_acc;
                        if (glb_length > size_reg) begin
                            ends = 1'b1;
                            code = glb_pkg::ST_LEN_SIZE;
                        end else begin
                            chunk_boundary(ends, code);
                        end
                    end
                end
            end
            glb_pkg::PH_CHDR: begin
                shift_in(b);
                if (word_bytes == glb_pkg::FBC_WORD0) begin
                    chunk_left = word_acc;
                end else if (word_bytes == glb_pkg::FBC_WORD1) begin
                    if (file_pos > size_reg || file_pos > glb_length ||
                        chunk_left > glb_length - file_pos) begin
                        ends = 1'b1;
                        code = glb_pkg::ST_OVERRUN;
                    end else if (word_acc == glb_pkg::GLB_JSON_TYPE) begin
                        if (chunk_left == 32'd0) begin
                            ends = 1'b1;
                            code = glb_pkg::ST_OK;
                        end else begin
                            parse_phase = glb_pkg::PH_JSON;
                        end
                    end else begin
                        if (chunk_left == 32'd0) chunk_boundary(ends, code);
                        else parse_phase = glb_pkg::PH_SKIP;
                    end
                end
            end
            glb_pkg::PH_SKIP: begin
                file_pos   = file_pos + 32'd1;
                chunk_left = chunk_left - 32'd1;
                if (chunk_left == 32'd0) chunk_boundary(ends, code);
            end
            glb_pkg::PH_JSON: begin
                payload    = 1'b1;
                file_pos   = file_pos + 32'd1;
                chunk_left = chunk_left - 32'd1;
                if (chunk_left == 32'd0) begin
                    ends = 1'b1;
                    code = glb_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        if (ends) parse_phase = glb_pkg::PH_DONE;
        // end of file cuts an unfinished file short and restarts the parser
        if (eof) begin
            if (!was_done && !ends) begin
                ends = 1'b1;
                code = glb_pkg::ST_SHORT;
            end
            clear_parse();
        end
        if (ends || payload) begin
            r.out_byte   = payload ? b : 8'd0;
            r.is_payload = payload;
            r.is_end     = ends;
            r.status     = ends ? code : glb_pkg::ST_OK;
            json_out_q.push_back(r);
        end
    endtask

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        fail_count++;
    endtask

    // compare results first, so a result never matches a request of the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            size_reg = glb_pkg::FILE_SIZE_RST;
            clear_parse();
            json_out_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (json_out_q.size() == 0) begin
                    $error("result with nothing expected: tdata %0h", m_tdata);
                    fail_count++;
                end else begin
                    oldest = json_out_q.pop_front();
                    if (m_tdata[7:0] !== oldest.out_byte)
                        flag_field("out_byte", oldest.out_byte, m_tdata[7:0]);
                    if (m_tdata[10:8] !== oldest.status)
                        flag_field("status", oldest.status, m_tdata[10:8]);
                    if (m_tdata[15:11] !== 5'd0)
                        flag_field("tdata pad", 32'd0, m_tdata[15:11]);
                    if (m_tuser !== oldest.is_payload)
                        flag_field("is_payload", oldest.is_payload, m_tuser);
                    if (m_tlast !== oldest.is_end)
                        flag_field("is_end", oldest.is_end, m_tlast);
                end
            end
            if (cfg_valid && cfg_ready === 1'b1) size_reg = cfg_data;
            if (s_tvalid && s_tready === 1'b1) locate_step(s_tdata, s_tlast);
        end
        pending = json_out_q.size();
    end

endmodule

// ===== test/glb_json_chunk_locator_tb.sv =====
// testbench top for the glb json chunk locator: clock, reset, file size writes,
// byte stimulus of whole and damaged GLB files, result back-pressure and verdict
// depends on glb_pkg, glb_json_chunk_locator and glb_json_chunk_locator_checker
module glb_json_chunk_locator_tb;

    localparam int          ITEM_TARGET   = 1500;
    localparam int          LONG_HOLD     = 300;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam longint      RUN_LIMIT     = 64'd10_000_000;
    localparam logic [31:0] BIN_TYPE      = 32'h004E_4942;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = 32'd0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    logic        pressure_req   = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned bytes_sent     = 0;
    logic [7:0]  glb_bytes[$];
    logic [31:0] size_val;

    glb_json_chunk_locator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    glb_json_chunk_locator_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    // result side back-pressure, with one long hold-off on request
    initial begin
        logic        ready_val;
        int unsigned len;
        int unsigned pick;
        forever begin
            pick = $urandom_range(0, 99);
            if (pressure_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                ready_val      = 1'b0;
                len            = LONG_HOLD;
            end else if (pick < 5) begin
                ready_val = 1'b1;
                len       = $urandom_range(100, 200);
            end else if (pick < 65) begin
                ready_val = 1'b1;
                len       = $urandom_range(1, 20);
            end else if (pick < 95) begin
                ready_val = 1'b0;
                len       = $urandom_range(1, 3);
            end else begin
                ready_val = 1'b0;
                len       = $urandom_range(20, 60);
            end
            m_tready <= ready_val;
            for (int i = 0; i < len; i++) begin
                @(posedge aclk);
                if (pressure_req && !long_hold_done) break;
            end
        end
    end

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) glb_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic set_word(input int unsigned at, input logic [31:0] w);
        for (int i = 0; i < 4; i++) glb_bytes[at + i] = w[8*i +: 8];
    endtask

    task automatic write_file_size(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one byte request, after a random gap unless the file goes out steady
    task automatic send_byte(input logic [7:0] b, input logic last, input bit steady);
        int unsigned gap;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 60) gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_glb(input bit steady);
        for (int unsigned idx = 0; idx < glb_bytes.size(); idx++)
            send_byte(glb_bytes[idx], idx == glb_bytes.size() - 1, steady);
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic wait_idle();
        int unsigned n;
        s_tvalid <= 1'b0;
        n = 0;
        do begin
            @(posedge aclk);
            n++;
        end while (pending != 0 && n < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // build one file, mostly well formed, else damaged in one chosen way
    task automatic build_random_glb(output logic [31:0] fsize, input bit clean,
                                    input int unsigned json_min,
                                    input int unsigned json_max);
        int unsigned flaw;
        int unsigned n_pre;
        int unsigned json_len;
        int unsigned json_at;
        int unsigned total;
        int unsigned cut;
        logic [31:0] clen;
        logic [31:0] glb_len;
        bit          has_json;
        flaw = clean ? 150 : $urandom_range(0, 149);
        glb_bytes.delete();
        // plain noise
        if (flaw < 6) begin
            repeat ($urandom_range(1, 30)) glb_bytes.push_back(8'($urandom_range(0, 255)));
            fsize = $urandom_range(1, 40);
            return;
        end
        has_json = !(flaw >= 12 && flaw < 18);
        n_pre    = $urandom_range(0, 2);
        if (flaw < 12 && n_pre == 0) n_pre = 1;
        put_word(glb_pkg::GLB_MAGIC);
        put_word(glb_pkg::GLB_VERSION);
        put_word(32'd0);
        // chunks ahead of the json one; a first length off a multiple of four breaks alignment
        for (int unsigned k = 0; k < n_pre + (has_json ? 0 : 1); k++) begin
            clen = 32'(4 * $urandom_range(0, 4));
            if (flaw < 12 && k == 0) clen = clen + 32'($urandom_range(1, 3));
            put_word(clen);
            put_word($urandom_range(0, 1) ? BIN_TYPE :
                     glb_pkg::GLB_JSON_TYPE ^ (32'd1 << $urandom_range(0, 31)));
            repeat (clen) glb_bytes.push_back(8'($urandom_range(0, 255)));
        end
        json_at = glb_bytes.size();
        if (has_json) begin
            json_len = ($urandom_range(0, 9) == 0) ? json_min :
                       $urandom_range(json_min + 1, json_max);
            put_word(json_len);
            put_word(glb_pkg::GLB_JSON_TYPE);
            repeat (json_len) glb_bytes.push_back(8'($urandom_range(0, 255)));
        end
        // trailing chunk that the parser reaches only in a file without a json chunk
        if ($urandom_range(0, 2) == 0) begin
            put_word(32'd4);
            put_word(BIN_TYPE);
            put_word($urandom);
        end
        total   = glb_bytes.size();
        glb_len = total;
        case ($urandom_range(0, 9))
            0:       fsize = 32'hFFFF_FFFF;
            1:       fsize = total + $urandom_range(1, 16);
            default: fsize = total;
        endcase
        if (flaw >= 18 && flaw < 24) begin
            glb_bytes[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (flaw >= 24 && flaw < 30) begin
            glb_bytes[$urandom_range(4, 7)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (flaw >= 30 && flaw < 36) begin
            // json chunk claims more than the declared length holds
            if ($urandom_range(0, 1) == 0)
                set_word(json_at, 32'(total - json_at - 8 + $urandom_range(1, 8)));
            else
                set_word(json_at, $urandom | 32'h8000_0000);
        end else if (flaw >= 36 && flaw < 42) begin
            glb_len = total - $urandom_range(1, 12);
        end else if (flaw >= 42 && flaw < 48) begin
            fsize = $urandom_range(12, total - 1);
        end else if (flaw >= 48 && flaw < 54) begin
            fsize = $urandom_range(1, 11);
        end else if (flaw >= 66 && flaw < 70) begin
            glb_bytes[$urandom_range(0, total - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end
        set_word(8, glb_len);
        // early end of file, or stray bytes after the end
        if (flaw >= 54 && flaw < 60) begin
            cut = $urandom_range(1, total - 1);
            while (glb_bytes.size() > cut) void'(glb_bytes.pop_back());
        end else if (flaw >= 60 && flaw < 66) begin
            repeat ($urandom_range(1, 6)) glb_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // size below the header, smallest and largest byte
        write_file_size(32'd1);
        glb_bytes.delete();
        glb_bytes.push_back(8'h00);
        send_glb(1'b0);
        wait_idle();
        write_file_size(32'd11);
        glb_bytes.delete();
        glb_bytes.push_back(8'hFF);
        send_glb(1'b0);
        wait_idle();

        // bad magic, then one byte past the end that carries the end flag
        write_file_size(glb_pkg::GLB_HDR_BYTES);
        glb_bytes.delete();
        put_word(glb_pkg::GLB_MAGIC ^ 32'h0100_0000);
        glb_bytes.push_back(8'h5A);
        send_glb(1'b1);
        wait_idle();

        // smallest whole file: empty json chunk right after the header
        write_file_size(32'hFFFF_FFFF);
        glb_bytes.delete();
        put_word(glb_pkg::GLB_MAGIC);
        put_word(glb_pkg::GLB_VERSION);
        put_word(32'd20);
        put_word(32'd0);
        put_word(glb_pkg::GLB_JSON_TYPE);
        send_glb(1'b0);

        // long payload sent steady while the result side holds off
        build_random_glb(size_val, 1'b1, 150, 200);
        wait_idle();
        write_file_size(size_val);
        pressure_req <= 1'b1;
        send_glb(1'b1);

        // random files, some back to back under one file size
        while (bytes_sent < ITEM_TARGET) begin
            build_random_glb(size_val, 1'b0, 0, 40);
            if ($urandom_range(0, 4) != 0) begin
                wait_idle();
                write_file_size(size_val);
            end
            send_glb($urandom_range(0, 7) == 0);
        end
        wait_idle();

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/glb_pkg.sv
rtl/glb_core.sv
rtl/glb_out_skid.sv
rtl/glb_json_chunk_locator.sv
test/glb_json_chunk_locator_checker.sv
test/glb_json_chunk_locator_tb.sv
